@@ rtl/core/dura_pkg.sv @@
package dura_pkg;

  localparam int TICK_W  = 16;
  localparam int SUM_W   = 18;
  localparam int SCALE_W = 23;
  localparam int DIST_W  = 21;
  localparam int SHOT_W  = 2;
  localparam int GOOD_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [TICK_W-1:0] TRIG_LOW_RST  = 16'd400;
  localparam logic [TICK_W-1:0] TRIG_HIGH_RST = 16'd50;
  localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd800;

  // ceil(2^23 / 3): exact floor division by three for values below 2^23
  localparam int DIV3_SHIFT = 23;
  localparam int DIV3_W     = 22;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 22'h2AAAAB;

  typedef enum logic [1:0] {
    TICK_HOLD,
    TICK_CLEAR,
    TICK_ONE,
    TICK_INC
  } tick_op_t;

  typedef struct packed {
    tick_op_t tick_op;
    logic     sel;
    logic     burst_clear;
    logic     store_pending;
    logic     accumulate;
    logic     load_scaled;
    logic     divide;
    logic     out_load;
    logic     trig_a;
    logic     trig_b;
    logic     busy;
    logic     done;
  } dura_cmd_t;

  typedef struct packed {
    logic start;
    logic echo_a;
    logic echo_b;
    logic ge_low;
    logic ge_high;
    logic ge_to_next;
    logic ge_to;
  } dura_status_t;

endpackage

@@ rtl/core/dura_in_if.sv @@
interface dura_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_a;
  logic echo_b;

  modport source (output valid, start_req, echo_a, echo_b, input ready);
  modport sink   (input valid, start_req, echo_a, echo_b, output ready);
endinterface

@@ rtl/core/dura_out_if.sv @@
interface dura_out_if;
  logic                        valid;
  logic                        ready;
  logic                        trig_a;
  logic                        trig_b;
  logic                        busy_res;
  logic                        done_res;
  logic [dura_pkg::DIST_W-1:0] distance_a;
  logic [dura_pkg::DIST_W-1:0] distance_b;
  logic [dura_pkg::GOOD_W-1:0] good_shots;

  modport source (output valid, trig_a, trig_b, busy_res, done_res, distance_a, distance_b,
                  good_shots, input ready);
  modport sink   (input valid, trig_a, trig_b, busy_res, done_res, distance_a, distance_b,
                  good_shots, output ready);
endinterface

@@ rtl/core/dura_ctrl.sv @@
module dura_ctrl #(
  parameter int SHOTS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  dura_pkg::dura_status_t status,
  output dura_pkg::dura_cmd_t    cmd
);

  typedef enum logic [2:0] {
    C_RUN,
    C_LOAD_A,
    C_DIV_A,
    C_LOAD_B,
    C_DIV_B,
    C_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TLOW,
    PH_THIGH,
    PH_RISE,
    PH_FALL
  } phase_t;

  ctrl_state_t                   state, state_next;
  phase_t                        phase, phase_next;
  logic                          sensor_sel, sensor_sel_next;
  logic [dura_pkg::SHOT_W-1:0]   shot_index, shot_index_next;
  logic [dura_pkg::SHOT_W-1:0]   shot_inc;
  logic                          shot_failed, shot_failed_next;
  logic                          out_valid_next;
  logic                          fire;
  logic                          end_now;
  logic                          end_ok;
  logic                          burst_end;
  logic                          echo;

  assign shot_inc = shot_index + 2'd1;
  assign echo     = sensor_sel ? status.echo_b : status.echo_a;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    sensor_sel_next  = sensor_sel;
    shot_index_next  = shot_index;
    shot_failed_next = shot_failed;
    cmd              = '0;
    cmd.tick_op      = dura_pkg::TICK_HOLD;
    cmd.sel          = sensor_sel;
    end_now          = 1'b0;
    end_ok           = 1'b0;
    burst_end        = 1'b0;
    in_ready         = (state == C_RUN) && (!out_valid || out_ready);
    fire             = in_valid && in_ready;

    case (state)
      C_RUN: begin
        if (fire) begin
          case (phase)
            PH_TLOW: begin
              if (status.ge_low) begin
                phase_next  = PH_THIGH;
                cmd.tick_op = dura_pkg::TICK_CLEAR;
              end else begin
                cmd.tick_op = dura_pkg::TICK_INC;
              end
            end
            PH_THIGH: begin
              if (status.ge_high) begin
                phase_next  = PH_RISE;
                cmd.tick_op = dura_pkg::TICK_CLEAR;
              end else begin
                cmd.tick_op = dura_pkg::TICK_INC;
              end
            end
            PH_RISE: begin
              if (echo) begin
                phase_next  = PH_FALL;
                cmd.tick_op = dura_pkg::TICK_ONE;
              end else if (status.ge_to_next) begin
                end_now = 1'b1;
              end else begin
                cmd.tick_op = dura_pkg::TICK_INC;
              end
            end
            PH_FALL: begin
              if (!echo) begin
                end_now = 1'b1;
                end_ok  = 1'b1;
              end else if (status.ge_to) begin
                end_now = 1'b1;
              end else begin
                cmd.tick_op = dura_pkg::TICK_INC;
              end
            end
            default: begin
              phase_next = PH_IDLE;
              if (status.start) begin
                phase_next       = PH_TLOW;
                sensor_sel_next  = 1'b0;
                shot_index_next  = '0;
                shot_failed_next = 1'b0;
                cmd.tick_op      = dura_pkg::TICK_CLEAR;
                cmd.burst_clear  = 1'b1;
              end
            end
          endcase

          if (end_now) begin
            cmd.tick_op = dura_pkg::TICK_CLEAR;
            if (!sensor_sel) begin
              cmd.store_pending = end_ok;
              if (!end_ok) begin
                shot_failed_next = 1'b1;
              end
              sensor_sel_next = 1'b1;
              phase_next      = PH_TLOW;
            end else begin
              cmd.accumulate   = end_ok && !shot_failed;
              sensor_sel_next  = 1'b0;
              shot_failed_next = 1'b0;
              if (shot_inc >= dura_pkg::SHOT_W'(SHOTS)) begin
                burst_end       = 1'b1;
                phase_next      = PH_IDLE;
                shot_index_next = '0;
              end else begin
                phase_next      = PH_TLOW;
                shot_index_next = shot_inc;
              end
            end
          end

          if (burst_end) begin
            state_next = C_LOAD_A;
          end else begin
            cmd.out_load = 1'b1;
            cmd.trig_a   = (phase_next == PH_THIGH) && !sensor_sel_next;
            cmd.trig_b   = (phase_next == PH_THIGH) && sensor_sel_next;
            cmd.busy     = (phase_next != PH_IDLE);
          end
        end
      end
      C_LOAD_A: begin
        cmd.sel         = 1'b0;
        cmd.load_scaled = 1'b1;
        state_next      = C_DIV_A;
      end
      C_DIV_A: begin
        cmd.sel    = 1'b0;
        cmd.divide = 1'b1;
        state_next = C_LOAD_B;
      end
      C_LOAD_B: begin
        cmd.sel         = 1'b1;
        cmd.load_scaled = 1'b1;
        state_next      = C_DIV_B;
      end
      C_DIV_B: begin
        cmd.sel    = 1'b1;
        cmd.divide = 1'b1;
        state_next = C_EMIT;
      end
      C_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.done     = 1'b1;
          state_next   = C_RUN;
        end
      end
      default: begin
        state_next = C_RUN;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= C_RUN;
      phase       <= PH_IDLE;
      sensor_sel  <= 1'b0;
      shot_index  <= '0;
      shot_failed <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      sensor_sel  <= sensor_sel_next;
      shot_index  <= shot_index_next;
      shot_failed <= shot_failed_next;
      out_valid   <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/dura_dp.sv @@
module dura_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dura_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start_req,
  input  logic                            echo_a,
  input  logic                            echo_b,
  input  dura_pkg::dura_cmd_t             cmd,
  output dura_pkg::dura_status_t          status,
  output logic                            trig_a,
  output logic                            trig_b,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [dura_pkg::DIST_W-1:0]     distance_a,
  output logic [dura_pkg::DIST_W-1:0]     distance_b,
  output logic [dura_pkg::GOOD_W-1:0]     good_shots
);

  localparam int PROD_W = dura_pkg::SCALE_W + dura_pkg::DIV3_W;

  logic [dura_pkg::TICK_W-1:0]  trig_low_ticks;
  logic [dura_pkg::TICK_W-1:0]  trig_high_ticks;
  logic [dura_pkg::TICK_W-1:0]  timeout_ticks;
  logic [dura_pkg::TICK_W-1:0]  tick_count;
  logic [dura_pkg::TICK_W:0]    tick_inc;
  logic [dura_pkg::TICK_W-1:0]  pending_a;
  logic [dura_pkg::SUM_W-1:0]   sum_a;
  logic [dura_pkg::SUM_W-1:0]   sum_b;
  logic [dura_pkg::GOOD_W-1:0]  good_count, good_count_next;
  logic [dura_pkg::DIST_W-1:0]  held_a;
  logic [dura_pkg::DIST_W-1:0]  held_b;
  logic [dura_pkg::SCALE_W-1:0] scaled;
  logic [dura_pkg::SUM_W-1:0]   sum_sel;
  logic [dura_pkg::SCALE_W-1:0] scaled_next;
  logic [PROD_W-1:0]            prod;
  logic [dura_pkg::DIST_W-1:0]  quot;

  assign tick_inc = {1'b0, tick_count} + 17'd1;

  assign status.start      = start_req;
  assign status.echo_a     = echo_a;
  assign status.echo_b     = echo_b;
  assign status.ge_low     = tick_inc >= {1'b0, trig_low_ticks};
  assign status.ge_high    = tick_inc >= {1'b0, trig_high_ticks};
  assign status.ge_to_next = tick_inc >= {1'b0, timeout_ticks};
  assign status.ge_to      = tick_count >= timeout_ticks;

  assign sum_sel     = cmd.sel ? sum_b : sum_a;
  assign scaled_next = {1'b0, sum_sel, 4'b0000} + {5'b00000, sum_sel};
  assign prod        = {{dura_pkg::DIV3_W{1'b0}}, scaled}
                     * {{dura_pkg::SCALE_W{1'b0}}, dura_pkg::DIV3_MUL};

  always_comb begin
    case (good_count)
      2'd0:    quot = '0;
      2'd1:    quot = scaled[dura_pkg::DIST_W-1:0];
      2'd2:    quot = scaled[dura_pkg::DIST_W:1];
      default: quot = prod[dura_pkg::DIV3_SHIFT +: dura_pkg::DIST_W];
    endcase
  end

  always_comb begin
    if (cmd.burst_clear) begin
      good_count_next = '0;
    end else if (cmd.accumulate) begin
      good_count_next = good_count + 2'd1;
    end else begin
      good_count_next = good_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_low_ticks  <= dura_pkg::TRIG_LOW_RST;
      trig_high_ticks <= dura_pkg::TRIG_HIGH_RST;
      timeout_ticks   <= dura_pkg::TIMEOUT_RST;
      tick_count      <= '0;
      pending_a       <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
      good_count      <= '0;
      held_a          <= '0;
      held_b          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dura_pkg::CFG_TRIG_LOW:  trig_low_ticks  <= cfg_data;
          dura_pkg::CFG_TRIG_HIGH: trig_high_ticks <= cfg_data;
          dura_pkg::CFG_TIMEOUT:   timeout_ticks   <= cfg_data;
          default: ;
        endcase
      end

      case (cmd.tick_op)
        dura_pkg::TICK_CLEAR: tick_count <= '0;
        dura_pkg::TICK_ONE:   tick_count <= 16'd1;
        dura_pkg::TICK_INC:   tick_count <= tick_inc[dura_pkg::TICK_W-1:0];
        default:              tick_count <= tick_count;
      endcase

      if (cmd.burst_clear) begin
        pending_a <= '0;
        sum_a     <= '0;
        sum_b     <= '0;
      end else begin
        if (cmd.store_pending) begin
          pending_a <= tick_count;
        end
        if (cmd.accumulate) begin
          sum_a <= sum_a + {2'b00, pending_a};
          sum_b <= sum_b + {2'b00, tick_count};
        end
      end
      good_count <= good_count_next;

      if (cmd.divide) begin
        if (cmd.sel) begin
          held_b <= quot;
        end else begin
          held_a <= quot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_scaled) begin
      scaled <= scaled_next;
    end
    if (cmd.out_load) begin
      trig_a     <= cmd.trig_a;
      trig_b     <= cmd.trig_b;
      busy_res   <= cmd.busy;
      done_res   <= cmd.done;
      distance_a <= held_a;
      distance_b <= held_b;
      good_shots <= good_count_next;
    end
  end

endmodule

@@ rtl/core/dual_ultrasonic_ranger_avg_top.sv @@
// Channel  Direction  Payload
// in_ch    sink       start_req, echo_a, echo_b (one timer tick)
// out_ch   source     trig_a, trig_b, busy_res, done_res, distance_a, distance_b, good_shots
// cfg      write      cfg_we, cfg_index, cfg_data
//
// One tick per cycle; its result is registered and shows in the cycle after the transfer.
// The tick that ends a burst holds in_ch off while the shared scale and divide-by-count
// unit runs two steps for each sensor (load, then divide), then the result is loaded
// and registered onto out_ch.
// rst is synchronous: registers return to 400/50/800 ticks, phase idle, held distances zero.
// A result held on out_ch stalls in_ch and the burst-end load while out_ch is not ready.
module dual_ultrasonic_ranger_avg_top #(
  parameter int SHOTS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  dura_in_if.sink                         in_ch,
  dura_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dura_pkg::CFG_DATA_W-1:0] cfg_data
);

  dura_pkg::dura_cmd_t    cmd;
  dura_pkg::dura_status_t status;

  dura_ctrl #(
    .SHOTS (SHOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dura_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_req  (in_ch.start_req),
    .echo_a     (in_ch.echo_a),
    .echo_b     (in_ch.echo_b),
    .cmd        (cmd),
    .status     (status),
    .trig_a     (out_ch.trig_a),
    .trig_b     (out_ch.trig_b),
    .busy_res   (out_ch.busy_res),
    .done_res   (out_ch.done_res),
    .distance_a (out_ch.distance_a),
    .distance_b (out_ch.distance_b),
    .good_shots (out_ch.good_shots)
  );

endmodule

@@ rtl/core/dura_chk.sv @@
module dura_chk (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic trig_a,
  input logic trig_b,
  input logic busy_res,
  input logic done_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_trigger: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_a && trig_b))
    else $error("both triggers driven");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !trig_a && !trig_b)
    else $error("burst end while busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (trig_a || trig_b) |-> busy_res && !done_res)
    else $error("trigger outside burst");

endmodule

bind dual_ultrasonic_ranger_avg_top dura_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .trig_a    (out_ch.trig_a),
  .trig_b    (out_ch.trig_b),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res)
);

@@ sim/dual_ultrasonic_ranger_avg_top_tb.sv @@
module dual_ultrasonic_ranger_avg_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BURST_SHOTS = 3;
  localparam logic [dura_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_AFTER = 200;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    RG_IDLE,
    RG_PING_LOW,
    RG_PING_HIGH,
    RG_ECHO_RISE,
    RG_ECHO_FALL
  } ranger_phase_t;

  typedef struct packed {
    ranger_phase_t               phase;
    logic                        sel;
    logic [dura_pkg::SHOT_W-1:0] shot;
    logic [dura_pkg::TICK_W-1:0] ticks;
    logic                        failed;
    logic [dura_pkg::TICK_W-1:0] pend_a;
    logic [dura_pkg::SUM_W-1:0]  sum_a;
    logic [dura_pkg::SUM_W-1:0]  sum_b;
    logic [dura_pkg::GOOD_W-1:0] good;
    logic [dura_pkg::DIST_W-1:0] dist_a;
    logic [dura_pkg::DIST_W-1:0] dist_b;
  } ranger_state_t;

  typedef struct packed {
    logic [dura_pkg::TICK_W-1:0] low_ticks;
    logic [dura_pkg::TICK_W-1:0] high_ticks;
    logic [dura_pkg::TICK_W-1:0] timeout_ticks;
  } ranger_cfg_t;

  typedef struct packed {
    logic start;
    logic echo_a;
    logic echo_b;
  } ranger_tick_t;

  typedef struct packed {
    logic                        trig_a;
    logic                        trig_b;
    logic                        busy;
    logic                        done;
    logic [dura_pkg::DIST_W-1:0] dist_a;
    logic [dura_pkg::DIST_W-1:0] dist_b;
    logic [dura_pkg::GOOD_W-1:0] good;
  } ranger_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic drv_valid = 1'b0;
  logic drv_start = 1'b0;
  logic drv_echo_a = 1'b0;
  logic drv_echo_b = 1'b0;
  logic rcv_ready = 1'b0;

  logic                            cfg_we = 1'b0;
  logic [dura_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dura_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ranger_cfg_t    ranger_cfg = '{dura_pkg::TRIG_LOW_RST, dura_pkg::TRIG_HIGH_RST,
                                 dura_pkg::TIMEOUT_RST};
  ranger_state_t  model_state = '0;
  ranger_state_t  gen_state = '0;
  ranger_tick_t   tick_q[$];
  ranger_result_t expected_q[$];

  ranger_tick_t   next_tick;
  ranger_tick_t   seen_tick;
  ranger_result_t want;
  ranger_result_t got_want;

  int   fail_count = 0;
  logic pace_on = 1'b1;
  int   gap_left = 0;
  int   hold_left = 0;
  int   taken_count = 0;
  logic long_hold_done = 1'b0;

  dura_in_if in_ch();
  dura_out_if out_ch();

  assign in_ch.valid     = drv_valid;
  assign in_ch.start_req = drv_start;
  assign in_ch.echo_a    = drv_echo_a;
  assign in_ch.echo_b    = drv_echo_b;
  assign out_ch.ready    = rcv_ready;

  dual_ultrasonic_ranger_avg_top #(
    .SHOTS(BURST_SHOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [dura_pkg::DIST_W-1:0] mean_distance(
      input logic [dura_pkg::SUM_W-1:0] sum, input logic [dura_pkg::GOOD_W-1:0] shots);
    int unsigned scaled;
    if (shots == 0) return '0;
    scaled = sum;
    scaled = (scaled * 17) / shots;
    return scaled[dura_pkg::DIST_W-1:0];
  endfunction

  function automatic ranger_state_t finish_sensor(input ranger_state_t s, input logic ok,
                                                  input logic [dura_pkg::TICK_W-1:0] dur,
                                                  output logic burst_done);
    burst_done = 1'b0;
    s.ticks = '0;
    if (!s.sel) begin
      if (ok) s.pend_a = dur;
      else s.failed = 1'b1;
      s.sel = 1'b1;
      s.phase = RG_PING_LOW;
      return s;
    end
    if (ok && !s.failed) begin
      s.sum_a = s.sum_a + s.pend_a;
      s.sum_b = s.sum_b + dur;
      s.good = s.good + 1'b1;
    end
    s.shot = s.shot + 1'b1;
    s.sel = 1'b0;
    s.failed = 1'b0;
    if (s.shot >= BURST_SHOTS) begin
      s.dist_a = mean_distance(s.sum_a, s.good);
      s.dist_b = mean_distance(s.sum_b, s.good);
      s.phase = RG_IDLE;
      s.shot = '0;
      burst_done = 1'b1;
    end else begin
      s.phase = RG_PING_LOW;
    end
    return s;
  endfunction

  function automatic ranger_state_t ranger_tick(input ranger_state_t s, input ranger_cfg_t c,
                                                input ranger_tick_t t,
                                                output ranger_result_t r);
    logic echo;
    logic done;
    echo = s.sel ? t.echo_b : t.echo_a;
    done = 1'b0;
    case (s.phase)
      RG_PING_LOW: begin
        if (int'(s.ticks) + 1 >= int'(c.low_ticks)) begin
          s.phase = RG_PING_HIGH;
          s.ticks = '0;
        end else begin
          s.ticks = s.ticks + 1'b1;
        end
      end
      RG_PING_HIGH: begin
        if (int'(s.ticks) + 1 >= int'(c.high_ticks)) begin
          s.phase = RG_ECHO_RISE;
          s.ticks = '0;
        end else begin
          s.ticks = s.ticks + 1'b1;
        end
      end
      RG_ECHO_RISE: begin
        if (echo) begin
          s.phase = RG_ECHO_FALL;
          s.ticks = 1;
        end else if (int'(s.ticks) + 1 >= int'(c.timeout_ticks)) begin
          s = finish_sensor(s, 1'b0, '0, done);
        end else begin
          s.ticks = s.ticks + 1'b1;
        end
      end
      RG_ECHO_FALL: begin
        if (!echo) begin
          s = finish_sensor(s, 1'b1, s.ticks, done);
        end else if (s.ticks >= c.timeout_ticks) begin
          s = finish_sensor(s, 1'b0, '0, done);
        end else begin
          s.ticks = s.ticks + 1'b1;
        end
      end
      default: begin
        s.phase = RG_IDLE;
        if (t.start) begin
          s.phase = RG_PING_LOW;
          s.sel = 1'b0;
          s.shot = '0;
          s.ticks = '0;
          s.failed = 1'b0;
          s.pend_a = '0;
          s.sum_a = '0;
          s.sum_b = '0;
          s.good = '0;
        end
      end
    endcase
    r.trig_a = (s.phase == RG_PING_HIGH) && !s.sel;
    r.trig_b = (s.phase == RG_PING_HIGH) && s.sel;
    r.busy = (s.phase != RG_IDLE);
    r.done = done;
    r.dist_a = s.dist_a;
    r.dist_b = s.dist_b;
    r.good = s.good;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  task automatic push_tick(input ranger_tick_t t);
    ranger_result_t unused;
    gen_state = ranger_tick(gen_state, ranger_cfg, t, unused);
    tick_q.push_back(t);
  endtask

  // Shape echoes to the shadow state so most bursts see real pings; the rest is noise.
  task automatic plan_bursts(input int bursts, input int noise_pct);
    ranger_tick_t t;
    int   started;
    int   r;
    int   to;
    int   cap;
    int   rise_wait;
    int   echo_len;
    logic noisy;
    logic echo;
    started = 0;
    noisy = 1'b0;
    rise_wait = 0;
    echo_len = 1;
    to = int'(ranger_cfg.timeout_ticks);
    while (started < bursts || gen_state.phase != RG_IDLE) begin
      t.start = 1'b0;
      t.echo_a = $urandom_range(1);
      t.echo_b = $urandom_range(1);
      if (gen_state.phase == RG_IDLE) begin
        if (started < bursts && $urandom_range(3) == 0) begin
          t.start = 1'b1;
          started++;
          noisy = ($urandom_range(99) < noise_pct);
        end
      end else begin
        t.start = ($urandom_range(7) == 0);
        if (gen_state.phase == RG_PING_HIGH && gen_state.ticks == 0) begin
          r = $urandom_range(99);
          cap = (to - 1 < 10) ? to - 1 : 10;
          if (cap < 0) cap = 0;
          if (to <= 1000 && r < 10) rise_wait = (to > 0) ? to : 1;
          else if (r < 20) rise_wait = cap;
          else rise_wait = $urandom_range(0, cap);
          r = $urandom_range(99);
          cap = (to < 12) ? to : 12;
          if (cap < 1) cap = 1;
          if (to <= 1000 && r < 10) echo_len = to + 1 + ((to == 0) ? 1 : 0);
          else if (r < 20) echo_len = (to > 0) ? to : 1;
          else echo_len = $urandom_range(1, cap);
        end
        if (!noisy && (gen_state.phase == RG_ECHO_RISE || gen_state.phase == RG_ECHO_FALL))
        begin
          if (gen_state.phase == RG_ECHO_RISE) echo = (gen_state.ticks >= rise_wait);
          else echo = (gen_state.ticks < echo_len);
          if (gen_state.sel) t.echo_b = echo;
          else t.echo_a = echo;
        end
      end
      push_tick(t);
    end
  endtask

  task automatic settle();
    while (tick_q.size() != 0 || drv_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dura_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dura_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dura_pkg::CFG_TRIG_LOW: ranger_cfg.low_ticks = val;
      dura_pkg::CFG_TRIG_HIGH: ranger_cfg.high_ticks = val;
      dura_pkg::CFG_TIMEOUT: ranger_cfg.timeout_ticks = val;
      default: ;
    endcase
  endtask

  task automatic write_cfg(input logic [dura_pkg::CFG_DATA_W-1:0] low,
                           input logic [dura_pkg::CFG_DATA_W-1:0] high,
                           input logic [dura_pkg::CFG_DATA_W-1:0] to);
    write_reg(dura_pkg::CFG_TRIG_LOW, low);
    write_reg(dura_pkg::CFG_TRIG_HIGH, high);
    write_reg(dura_pkg::CFG_TIMEOUT, to);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      gap_left = 0;
    end else if (!drv_valid || in_ch.ready) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left--;
      end else if (tick_q.size() != 0) begin
        next_tick = tick_q.pop_front();
        drv_valid <= 1'b1;
        drv_start <= next_tick.start;
        drv_echo_a <= next_tick.echo_a;
        drv_echo_b <= next_tick.echo_b;
        gap_left = pace_on ? pick_gap() : 0;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen_tick.start = in_ch.start_req;
      seen_tick.echo_a = in_ch.echo_a;
      seen_tick.echo_b = in_ch.echo_b;
      model_state = ranger_tick(model_state, ranger_cfg, seen_tick, want);
      expected_q.push_back(want);
    end
  end

  // Hold off once for a long stretch so the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) taken_count++;
      if (!long_hold_done && taken_count >= LONG_HOLD_AFTER) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && pace_on) begin
        hold_left = pick_gap();
      end
      if (hold_left != 0) begin
        rcv_ready <= 1'b0;
        hold_left--;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        got_want = expected_q.pop_front();
        check_field("trig_a", got_want.trig_a, out_ch.trig_a);
        check_field("trig_b", got_want.trig_b, out_ch.trig_b);
        check_field("busy_res", got_want.busy, out_ch.busy_res);
        check_field("done_res", got_want.done, out_ch.done_res);
        check_field("distance_a", got_want.dist_a, out_ch.distance_a);
        check_field("distance_b", got_want.dist_b, out_ch.distance_b);
        check_field("good_shots", got_want.good, out_ch.good_shots);
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("dual_ultrasonic_ranger_avg_top_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int e = 0; e < 4; e++) begin
      push_tick(ranger_tick_t'{1'b0, e[1], e[0]});
    end
    settle();

    write_cfg(16'd0, 16'd0, 16'd0);
    plan_bursts(5, 20);
    settle();

    write_cfg(16'd1, 16'd1, 16'd1);
    write_reg(CFG_SPARE, 16'($urandom));
    plan_bursts(5, 20);

    for (int k = 0; k < 4; k++) begin
      settle();
      write_cfg($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(2, 14));
      plan_bursts(1, 15);
    end
    settle();

    pace_on = 1'b0;
    write_cfg(16'd2, 16'd1, 16'd6);
    plan_bursts(1, 0);
    settle();

    pace_on = 1'b1;
    write_cfg(16'd3, 16'd2, 16'd12);
    plan_bursts(2, 30);
    settle();

    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("dual_ultrasonic_ranger_avg_top_tb: PASS");
    end else begin
      $display("dual_ultrasonic_ranger_avg_top_tb: FAIL");
    end
    $finish;
  end

endmodule
